// File: rtl/tmt_pkg.sv
// shared types and constants for the multi-ant colour turmite
package tmt_pkg;

    localparam int COLOR_W    = 8;
    localparam int CELL_W     = 8;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int RULE_W     = 32;
    localparam int RLEN_W     = 6;
    localparam int CNT_CFG_W  = 9;
    localparam int SIZE_CFG_W = 9;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ANT_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_BITS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd5;

    // request opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    // headings
    localparam logic [DIR_W-1:0] DIR_Y_INC = 2'd0;
    localparam logic [DIR_W-1:0] DIR_X_DEC = 2'd1;
    localparam logic [DIR_W-1:0] DIR_Y_DEC = 2'd2;
    localparam logic [DIR_W-1:0] DIR_X_INC = 2'd3;

    localparam logic [DIR_W-1:0] DIR_START = DIR_X_DEC;

    // effective rule settings seen by the sequencer
    typedef struct packed {
        logic [RULE_W-1:0] rule_bits;
        logic [RLEN_W-1:0] rule_len;
        logic              wrap;
    } t_rule_cfg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ANT_RD,
        S_ANT_Q,
        S_GRID_Q,
        S_MOD,
        S_CELL,
        S_DONE
    } t_state;

endpackage

// File: rtl/multi_ant_color_turmite_unit.sv
// top level of the multi-ant colour turmite: sequencer, grid and ant memories
//
// usage
//   input channel (i_in_valid / o_in_ready) carries one request: opcode 0
//   advances every active ant one tick, opcode 1 reads the colour of cell
//   (i_cell_x, i_cell_y). each request gives exactly one result on the
//   output channel (o_out_valid / i_out_ready): the cell colour (zero for a
//   tick) and the sticky halt flag as it stands after the request.
//   configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are registered,
//   recentre every ant heading direction 1 and clear the halt flag; the user
//   must make them only while the block is idle, which the block does not enforce.
// timing
//   a cell read is registered out of the grid in the idle state, then passes
//   through S_CELL and S_DONE. a tick visits each active ant in turn: an ant
//   memory read, a grid read, and the shared bit-serial remainder unit that
//   reduces the colour modulo the rule length. o_in_ready is high only in
//   the idle state, so requests are handled one at a time.
// reset
//   synchronous, active low. afterwards a clearing pass writes zero to every
//   grid cell, one cell per cycle, with o_in_ready low.
//   config writes still land.
// stalls
//   the result sits in an output register; a new request is accepted while
//   it waits, and a finished result is held back until the register frees.
module multi_ant_color_turmite_unit #(
    parameter int MAX_GRID_W    = 256,
    parameter int MAX_GRID_H    = 256,
    parameter int MAX_ANT_COUNT = 256,
    parameter int RULE_BITS     = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_opcode,
    input  logic [tmt_pkg::CELL_W-1:0]     i_cell_x,
    input  logic [tmt_pkg::CELL_W-1:0]     i_cell_y,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [tmt_pkg::COLOR_W-1:0]    o_cell_color,
    output logic                           o_halted,
    // configuration port
    input  logic                           i_cfg_we,
    input  logic [tmt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tmt_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int XW   = $clog2(MAX_GRID_W);
    localparam int YW   = $clog2(MAX_GRID_H);
    localparam int GAW  = XW + YW;
    localparam int KW   = $clog2(MAX_ANT_COUNT + 1);
    localparam int AW   = (MAX_ANT_COUNT > 1) ? $clog2(MAX_ANT_COUNT) : 1;
    localparam int ADW  = XW + YW + tmt_pkg::DIR_W;
    localparam int GDEP = 2 ** GAW;

    // effective configuration
    tmt_pkg::t_rule_cfg rule;
    logic [KW-1:0]      ant_n;
    logic [XW:0]        grid_w;
    logic [YW:0]        grid_h;
    logic               recentre;

    // sequencer state
    tmt_pkg::t_state r_state, n_state;
    logic [KW-1:0]   r_k;
    logic [XW-1:0]   r_x;
    logic [YW-1:0]   r_y;
    logic [tmt_pkg::DIR_W-1:0] r_d;
    logic            r_halt;
    logic            r_fresh;
    logic [GAW-1:0]  r_clr_addr;
    logic            r_in_range;
    logic [tmt_pkg::COLOR_W-1:0] r_res_color;

    // output register
    logic                        r_out_valid;
    logic [tmt_pkg::COLOR_W-1:0] r_out_color;
    logic                        r_out_halted;

    // memories
    logic [tmt_pkg::COLOR_W-1:0] grid_mem [0:GDEP-1];
    logic [ADW-1:0]              ant_mem  [0:MAX_ANT_COUNT-1];
    logic [tmt_pkg::COLOR_W-1:0] r_grid_q;
    logic [ADW-1:0]              r_ant_q;

    // control strobes
    logic                        in_accept;
    logic                        out_load;
    logic                        grid_we;
    logic [GAW-1:0]              grid_waddr;
    logic [tmt_pkg::COLOR_W-1:0] grid_wdata;
    logic [GAW-1:0]              grid_raddr;
    logic                        ant_we;
    logic [AW-1:0]               ant_addr;
    logic                        mod_start;
    logic                        mod_done;
    logic [tmt_pkg::RLEN_W-1:0]  mod_rem;
    logic                        step_ok;
    logic                        step_halt;

    // datapath values
    logic [XW-1:0]             cen_x;
    logic [YW-1:0]             cen_y;
    logic [XW-1:0]             sel_x;
    logic [YW-1:0]             sel_y;
    logic [tmt_pkg::DIR_W-1:0] sel_d;
    logic [XW:0]               w_m1_full;
    logic [YW:0]               h_m1_full;
    logic [XW-1:0]             w_last;
    logic [YW-1:0]             h_last;
    logic                      turn_left;
    logic [tmt_pkg::DIR_W-1:0] nd;
    logic                      at_edge;
    logic [XW-1:0]             nx;
    logic [YW-1:0]             ny;
    logic                      last_ant;

    tmt_cfg_regs #(
        .MAX_GRID_W    (MAX_GRID_W),
        .MAX_GRID_H    (MAX_GRID_H),
        .MAX_ANT_COUNT (MAX_ANT_COUNT),
        .RULE_BITS     (RULE_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_rule      (rule),
        .o_ant_n     (ant_n),
        .o_grid_w    (grid_w),
        .o_grid_h    (grid_h),
        .o_recentre  (recentre)
    );

    tmt_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_grid_q),
        .i_divisor  (rule.rule_len),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // ant geometry and the move itself
    always_comb begin
        cen_x     = grid_w[XW:1];
        cen_y     = grid_h[YW:1];
        w_m1_full = grid_w - 1'b1;
        h_m1_full = grid_h - 1'b1;
        w_last    = w_m1_full[XW-1:0];
        h_last    = h_m1_full[YW-1:0];

        // a freshly recentred ant has not been written back yet
        if (r_fresh) begin
            sel_x = cen_x;
            sel_y = cen_y;
            sel_d = tmt_pkg::DIR_START;
        end else begin
            sel_x = r_ant_q[ADW-1 -: XW];
            sel_y = r_ant_q[tmt_pkg::DIR_W +: YW];
            sel_d = r_ant_q[tmt_pkg::DIR_W-1:0];
        end

        // rule bits above the register read as turn right
        turn_left = (mod_rem < tmt_pkg::RLEN_W'(tmt_pkg::RULE_W)) &&
                    rule.rule_bits[mod_rem[4:0]];
        nd = turn_left ? r_d + 2'd1 : r_d + 2'd3;

        nx = r_x;
        ny = r_y;
        case (nd)
            tmt_pkg::DIR_Y_INC: begin
                at_edge = (r_y == h_last);
                ny      = at_edge ? '0 : r_y + 1'b1;
            end
            tmt_pkg::DIR_X_DEC: begin
                at_edge = (r_x == '0);
                nx      = at_edge ? w_last : r_x - 1'b1;
            end
            tmt_pkg::DIR_Y_DEC: begin
                at_edge = (r_y == '0);
                ny      = at_edge ? h_last : r_y - 1'b1;
            end
            default: begin
                at_edge = (r_x == w_last);
                nx      = at_edge ? '0 : r_x + 1'b1;
            end
        endcase

        last_ant  = (r_k == KW'(1));
        step_halt = (r_state == tmt_pkg::S_MOD) && mod_done && !rule.wrap && at_edge;
        step_ok   = (r_state == tmt_pkg::S_MOD) && mod_done && !(!rule.wrap && at_edge);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tmt_pkg::S_CLEAR: begin
                if (r_clr_addr == '1) n_state = tmt_pkg::S_IDLE;
            end
            tmt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == tmt_pkg::OP_READ) begin
                        n_state = tmt_pkg::S_CELL;
                    end else if (r_halt || ant_n == '0) begin
                        n_state = tmt_pkg::S_DONE;
                    end else begin
                        n_state = tmt_pkg::S_ANT_RD;
                    end
                end
            end
            tmt_pkg::S_ANT_RD: n_state = tmt_pkg::S_ANT_Q;
            tmt_pkg::S_ANT_Q:  n_state = tmt_pkg::S_GRID_Q;
            tmt_pkg::S_GRID_Q: n_state = tmt_pkg::S_MOD;
            tmt_pkg::S_MOD: begin
                if (step_halt) begin
                    n_state = tmt_pkg::S_DONE;
                end else if (step_ok) begin
                    n_state = last_ant ? tmt_pkg::S_DONE : tmt_pkg::S_ANT_RD;
                end
            end
            tmt_pkg::S_CELL: n_state = tmt_pkg::S_DONE;
            tmt_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = tmt_pkg::S_IDLE;
            end
            default: n_state = tmt_pkg::S_IDLE;
        endcase
    end

    // control outputs of the sequencer
    always_comb begin
        in_accept  = (r_state == tmt_pkg::S_IDLE) && i_in_valid;
        out_load   = (r_state == tmt_pkg::S_DONE) && (!r_out_valid || i_out_ready);
        grid_we    = 1'b0;
        grid_waddr = {r_y, r_x};
        grid_wdata = r_grid_q + 1'b1;
        grid_raddr = {sel_y, sel_x};
        mod_start  = 1'b0;
        ant_we     = step_ok;
        ant_addr   = AW'(r_k - 1'b1);
        case (r_state)
            tmt_pkg::S_CLEAR: begin
                grid_we    = 1'b1;
                grid_waddr = r_clr_addr;
                grid_wdata = '0;
            end
            tmt_pkg::S_IDLE: begin
                grid_raddr = {YW'(i_cell_y), XW'(i_cell_x)};
            end
            tmt_pkg::S_GRID_Q: begin
                grid_we   = 1'b1;
                mod_start = 1'b1;
            end
            default: ;
        endcase
    end

    // grid colour store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
        r_grid_q <= grid_mem[grid_raddr];
    end

    // ant position and heading store
    always_ff @(posedge i_clk) begin
        if (ant_we) ant_mem[ant_addr] <= {nx, ny, nd};
        r_ant_q <= ant_mem[ant_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tmt_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_halt      <= 1'b0;
            r_fresh     <= 1'b1;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tmt_pkg::S_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;

            if (recentre) begin
                r_fresh <= 1'b1;
                r_halt  <= 1'b0;
            end else begin
                if (step_halt) r_halt <= 1'b1;
                // every active ant has now been written back
                if (step_ok && last_ant) r_fresh <= 1'b0;
            end

            if (in_accept) begin
                r_k <= ant_n;
            end else if (step_ok) begin
                r_k <= r_k - 1'b1;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_range  <= (32'(i_cell_x) < 32'(MAX_GRID_W)) &&
                           (32'(i_cell_y) < 32'(MAX_GRID_H));
            r_res_color <= '0;
        end
        if (r_state == tmt_pkg::S_CELL) begin
            r_res_color <= r_in_range ? r_grid_q : '0;
        end
        if (r_state == tmt_pkg::S_ANT_Q) begin
            r_x <= sel_x;
            r_y <= sel_y;
            r_d <= sel_d;
        end
        if (out_load) begin
            r_out_color  <= r_res_color;
            r_out_halted <= r_halt;
        end
    end

    assign o_in_ready   = (r_state == tmt_pkg::S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cell_color = r_out_color;
    assign o_halted     = r_out_halted;

endmodule

// File: rtl/tmt_mod_unit.sv
// iterative remainder unit, one quotient bit per cycle
module tmt_mod_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tmt_pkg::COLOR_W-1:0]   i_dividend,
    input  logic [tmt_pkg::RLEN_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [tmt_pkg::RLEN_W-1:0]    o_rem
);

    localparam int CW = $clog2(tmt_pkg::COLOR_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CW-1:0]               r_cnt;
    logic [tmt_pkg::COLOR_W-1:0] r_dvd;
    logic [tmt_pkg::RLEN_W-1:0]  r_div;
    logic [tmt_pkg::RLEN_W-1:0]  r_rem;

    logic [tmt_pkg::RLEN_W:0]    trial;
    logic [tmt_pkg::RLEN_W:0]    n_rem;

    // restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_dvd[tmt_pkg::COLOR_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = trial - {1'b0, r_div};
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(tmt_pkg::COLOR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[tmt_pkg::COLOR_W-2:0], 1'b0};
            r_rem <= n_rem[tmt_pkg::RLEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: rtl/tmt_cfg_regs.sv
// configuration registers and their clamped effective values
module tmt_cfg_regs #(
    parameter int MAX_GRID_W    = 256,
    parameter int MAX_GRID_H    = 256,
    parameter int MAX_ANT_COUNT = 256,
    parameter int RULE_BITS     = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tmt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tmt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output tmt_pkg::t_rule_cfg                o_rule,
    output logic [$clog2(MAX_ANT_COUNT+1)-1:0] o_ant_n,
    output logic [$clog2(MAX_GRID_W):0]       o_grid_w,
    output logic [$clog2(MAX_GRID_H):0]       o_grid_h,
    output logic                              o_recentre
);

    localparam int KW  = $clog2(MAX_ANT_COUNT + 1);
    localparam int XW  = $clog2(MAX_GRID_W);
    localparam int YW  = $clog2(MAX_GRID_H);
    localparam int NCW = (KW > tmt_pkg::CNT_CFG_W) ? KW : tmt_pkg::CNT_CFG_W;
    localparam int WCW = (XW + 1 > tmt_pkg::SIZE_CFG_W) ? XW + 1 : tmt_pkg::SIZE_CFG_W;
    localparam int HCW = (YW + 1 > tmt_pkg::SIZE_CFG_W) ? YW + 1 : tmt_pkg::SIZE_CFG_W;
    localparam int LCW = 8;

    logic [tmt_pkg::CNT_CFG_W-1:0]  r_ant_count;
    logic [tmt_pkg::RULE_W-1:0]     r_rule_bits;
    logic [tmt_pkg::RLEN_W-1:0]     r_rule_len;
    logic                           r_wrap;
    logic [tmt_pkg::SIZE_CFG_W-1:0] r_grid_w;
    logic [tmt_pkg::SIZE_CFG_W-1:0] r_grid_h;

    logic [NCW-1:0] cnt_ext;
    logic [WCW-1:0] w_ext;
    logic [HCW-1:0] h_ext;
    logic [LCW-1:0] len_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ant_count <= tmt_pkg::CNT_CFG_W'(1);
            r_rule_bits <= tmt_pkg::RULE_W'(1);
            r_rule_len  <= tmt_pkg::RLEN_W'(2);
            r_wrap      <= 1'b1;
            r_grid_w    <= tmt_pkg::SIZE_CFG_W'(256);
            r_grid_h    <= tmt_pkg::SIZE_CFG_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tmt_pkg::CFG_ANT_COUNT:   r_ant_count <= i_cfg_data[tmt_pkg::CNT_CFG_W-1:0];
                tmt_pkg::CFG_RULE_BITS:   r_rule_bits <= i_cfg_data[tmt_pkg::RULE_W-1:0];
                tmt_pkg::CFG_RULE_LENGTH: r_rule_len  <= i_cfg_data[tmt_pkg::RLEN_W-1:0];
                tmt_pkg::CFG_WRAP_ENABLE: r_wrap      <= i_cfg_data[0];
                tmt_pkg::CFG_GRID_WIDTH:  r_grid_w    <= i_cfg_data[tmt_pkg::SIZE_CFG_W-1:0];
                tmt_pkg::CFG_GRID_HEIGHT: r_grid_h    <= i_cfg_data[tmt_pkg::SIZE_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // any write to a known register puts the ants back at the start
    always_comb begin
        case (i_cfg_index)
            tmt_pkg::CFG_ANT_COUNT, tmt_pkg::CFG_RULE_BITS, tmt_pkg::CFG_RULE_LENGTH,
            tmt_pkg::CFG_WRAP_ENABLE, tmt_pkg::CFG_GRID_WIDTH,
            tmt_pkg::CFG_GRID_HEIGHT: o_recentre = i_cfg_we;
            default:                  o_recentre = 1'b0;
        endcase
    end

    always_comb begin
        cnt_ext = NCW'(r_ant_count);
        if (cnt_ext > NCW'(MAX_ANT_COUNT)) begin
            o_ant_n = KW'(MAX_ANT_COUNT);
        end else begin
            o_ant_n = KW'(cnt_ext);
        end

        w_ext = WCW'(r_grid_w);
        if (w_ext < WCW'(2)) begin
            o_grid_w = (XW+1)'(2);
        end else if (w_ext > WCW'(MAX_GRID_W)) begin
            o_grid_w = (XW+1)'(MAX_GRID_W);
        end else begin
            o_grid_w = (XW+1)'(w_ext);
        end

        h_ext = HCW'(r_grid_h);
        if (h_ext < HCW'(2)) begin
            o_grid_h = (YW+1)'(2);
        end else if (h_ext > HCW'(MAX_GRID_H)) begin
            o_grid_h = (YW+1)'(MAX_GRID_H);
        end else begin
            o_grid_h = (YW+1)'(h_ext);
        end

        len_ext = LCW'(r_rule_len);
        o_rule.rule_bits = r_rule_bits;
        o_rule.wrap      = r_wrap;
        if (len_ext == '0) begin
            o_rule.rule_len = tmt_pkg::RLEN_W'(1);
        end else if (len_ext > LCW'(RULE_BITS)) begin
            o_rule.rule_len = tmt_pkg::RLEN_W'(RULE_BITS);
        end else begin
            o_rule.rule_len = r_rule_len;
        end
    end

endmodule
